>>> hw/rtl/prd_pkg.sv
// shared types and constants for the prescaled reload down timer
// no dependencies
package prd_pkg;

    localparam int COUNT_W     = 16;
    localparam int PRESCALE_W  = 8;
    localparam int DIV_SEL_W   = 3;
    localparam int DIV_CNT_W   = 5;
    localparam int BUF_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIV_SEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_BUF = 2'd2;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_CTRL  = 1'b1;

    typedef struct packed {
        logic [PRESCALE_W-1:0] prescale;
        logic [DIV_SEL_W-1:0]  div_sel;
        logic [BUF_W-1:0]      count_buf;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic func;
        logic start_bit;
        logic manual_update;
        logic auto_reload;
    } t_step;

    typedef struct packed {
        logic advance;
        logic clear;
    } t_phase_ctl;

    // last divider phase: /2 -> 1 ... /32 -> 31, saturated above four
    function automatic logic [DIV_CNT_W-1:0] div_last(input logic [DIV_SEL_W-1:0] sel);
        logic [DIV_CNT_W-1:0] last;
        case (sel)
            3'd0:    last = 5'd1;
            3'd1:    last = 5'd3;
            3'd2:    last = 5'd7;
            3'd3:    last = 5'd15;
            default: last = 5'd31;
        endcase
        return last;
    endfunction

endpackage

>>> hw/rtl/prescaled_reload_down_timer.sv
// top level of the prescaled reload down timer: input and result registers, config
// depends on prd_pkg, prd_prescaler, prd_counter
//
//  channel  dir  handshake               payload
//  s        in   i_s_tvalid/o_s_tready   tuser: func; tdata: start, update, reload
//  m        out  o_m_tvalid/i_m_tready   tdata: count_observed, expired_irq, is_running
//  cfg      in   i_cfg_valid/o_cfg_ready index 0..2, data 16 bits
//
// one item per cycle unless the output stalls; the input register feeds the result register
// the counter state updates as an item leaves the input register
// a stalled result register holds the input register, one item may wait in each
// synchronous active-low reset clears the valid flags, timer state and config, not the result data
// config is always ready and takes effect on the next item
module prescaled_reload_down_timer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [prd_pkg::S_TDATA_W-1:0]     i_s_tdata,   // start_bit, manual_update, auto_reload, pad
    input  logic                              i_s_tuser,   // func
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [prd_pkg::M_TDATA_W-1:0]     o_m_tdata,   // count_observed[15:0], expired_irq, is_running, pad
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [prd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [prd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import prd_pkg::*;

    t_cfg               r_cfg;
    t_step              r_in;
    t_step              step;
    t_phase_ctl         ctl;
    logic               tick;
    logic               out_free;
    logic [COUNT_W-1:0] cnt_next;
    logic               irq_next;
    logic               run_next;
    logic               r_out_valid;
    logic [15:0]        r_out_count;
    logic               r_out_irq;
    logic               r_out_run;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PRESCALE:  r_cfg.prescale  <= i_cfg_data[PRESCALE_W-1:0];
                CFG_DIV_SEL:   r_cfg.div_sel   <= i_cfg_data[DIV_SEL_W-1:0];
                CFG_COUNT_BUF: r_cfg.count_buf <= i_cfg_data[BUF_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in.valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in <= '0;
        end else if (o_s_tready) begin
            r_in.valid         <= i_s_tvalid;
            r_in.func          <= i_s_tuser;
            r_in.start_bit     <= i_s_tdata[0];
            r_in.manual_update <= i_s_tdata[1];
            r_in.auto_reload   <= i_s_tdata[2];
        end
    end

    always_comb begin
        step       = r_in;
        step.valid = r_in.valid && out_free;
    end

    prd_prescaler u_prescaler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_ctl   (ctl),
        .o_tick  (tick)
    );

    prd_counter u_counter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_count_buf (r_cfg.count_buf),
        .i_tick      (tick),
        .o_ctl       (ctl),
        .o_count     (cnt_next),
        .o_irq       (irq_next),
        .o_run       (run_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step.valid) begin
            r_out_count <= 16'(cnt_next);
            r_out_irq   <= irq_next;
            r_out_run   <= run_next;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_run, r_out_irq, r_out_count};

endmodule

>>> hw/rtl/prd_prescaler.sv
// prescaler and binary divider phase counters
// depends on prd_pkg
module prd_prescaler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  prd_pkg::t_cfg                 i_cfg,
    input  prd_pkg::t_phase_ctl           i_ctl,
    output logic                          o_tick
);
    import prd_pkg::*;

    logic [PRESCALE_W-1:0] r_pre;
    logic [PRESCALE_W-1:0] n_pre;
    logic [DIV_CNT_W-1:0]  r_div;
    logic [DIV_CNT_W-1:0]  n_div;
    logic                  pre_wrap;
    logic                  div_wrap;

    assign pre_wrap = (r_pre >= i_cfg.prescale);
    assign div_wrap = (r_div >= div_last(i_cfg.div_sel));
    assign o_tick   = pre_wrap && div_wrap;

    always_comb begin
        n_pre = r_pre;
        n_div = r_div;
        if (i_ctl.clear) begin
            n_pre = '0;
            n_div = '0;
        end else if (i_ctl.advance) begin
            if (pre_wrap) begin
                n_pre = '0;
                n_div = div_wrap ? '0 : r_div + 1'b1;
            end else begin
                n_pre = r_pre + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre <= '0;
            r_div <= '0;
        end else begin
            r_pre <= n_pre;
            r_div <= n_div;
        end
    end

endmodule

>>> hw/rtl/prd_counter.sv
// down counter with run and auto-reload flags, raises the expiry pulse
// depends on prd_pkg; drives the phase control of prd_prescaler
module prd_counter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  prd_pkg::t_step                i_step,
    input  logic [prd_pkg::BUF_W-1:0]     i_count_buf,
    input  logic                          i_tick,
    output prd_pkg::t_phase_ctl           o_ctl,
    output logic [prd_pkg::COUNT_W-1:0]   o_count,
    output logic                          o_irq,
    output logic                          o_run
);
    import prd_pkg::*;

    logic [COUNT_W-1:0] r_cnt;
    logic [COUNT_W-1:0] n_cnt;
    logic               r_run;
    logic               n_run;
    logic               r_reload;
    logic               n_reload;
    logic               n_irq;
    logic [COUNT_W-1:0] dec;
    logic [COUNT_W-1:0] reload_val;

    assign dec        = r_cnt - 1'b1;
    assign reload_val = COUNT_W'(i_count_buf);

    assign o_ctl.advance = i_step.valid && (i_step.func == FUNC_TICK) && r_run;
    assign o_ctl.clear   = i_step.valid && (i_step.func == FUNC_CTRL) && i_step.manual_update;

    always_comb begin
        n_cnt    = r_cnt;
        n_run    = r_run;
        n_reload = r_reload;
        n_irq    = 1'b0;
        if (i_step.valid && (i_step.func == FUNC_CTRL)) begin
            n_run    = i_step.start_bit;
            n_reload = i_step.auto_reload;
            if (i_step.manual_update) begin
                n_cnt = reload_val;
            end
        end else if (o_ctl.advance && i_tick) begin
            if (r_cnt != '0) begin
                n_cnt = dec;
                if (dec == '0) begin
                    n_irq = 1'b1;
                    if (r_reload) begin
                        n_cnt = reload_val;
                    end else begin
                        n_run = 1'b0;
                    end
                end
            end else if (r_reload) begin
                n_cnt = reload_val;
            end else begin
                n_run = 1'b0;
            end
        end
    end

    assign o_count = n_cnt;
    assign o_irq   = n_irq;
    assign o_run   = n_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_run    <= 1'b0;
            r_reload <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_run    <= n_run;
            r_reload <= n_reload;
        end
    end

    a_irq_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_irq |-> (i_step.valid && (i_step.func == FUNC_TICK) && r_run))
        else $error("expiry pulse without a running tick");

    a_irq_from_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_irq |-> (r_cnt == COUNT_W'(1)))
        else $error("expiry pulse from a count other than one");

    a_one_shot_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_irq && !r_reload) |=> !r_run)
        else $error("one-shot timer kept running after expiry");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step.valid |=> ($stable(r_cnt) && $stable(r_run)))
        else $error("counter state moved without a transfer");

endmodule

>>> tb/prescaled_reload_down_timer_tb.sv
// self-checking testbench for prescaled_reload_down_timer: directed and random tick/control
// streams against an in-bench timer model, with config phases and random stalls on both sides
// depends on prd_pkg and prescaled_reload_down_timer
`timescale 1ns / 1ps

module prescaled_reload_down_timer_tb;
    import prd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 6;

    typedef struct packed {
        logic func;
        logic start_bit;
        logic manual_update;
        logic auto_reload;
    } t_timer_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0] count_observed;
        logic               expired_irq;
        logic               is_running;
    } t_timer_obs;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_valid;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  o_m_tvalid;
    logic                  m_ready;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    t_timer_cmd cmd_q[$];
    t_timer_obs expected_obs_q[$];
    int         src_idle_pct;
    int         snk_idle_pct;
    int         err_count;
    int         stall_cycles;

    // timer model state and its copy of the registers
    logic [PRESCALE_W-1:0] mdl_prescale;
    logic [DIV_SEL_W-1:0]  mdl_div_sel;
    logic [BUF_W-1:0]      mdl_count_buf;
    logic [PRESCALE_W-1:0] mdl_pre_cnt;
    logic [DIV_CNT_W-1:0]  mdl_div_cnt;
    logic [COUNT_W-1:0]    mdl_down_cnt;
    logic                  mdl_running;
    logic                  mdl_reloading;

    prescaled_reload_down_timer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_timer_obs predict_timer_step(input t_timer_cmd cmd);
        t_timer_obs           obs;
        logic [DIV_SEL_W-1:0] sel_sat;
        logic [DIV_CNT_W-1:0] div_term;
        logic                 divided_tick;
        obs.expired_irq = 1'b0;
        divided_tick = 1'b0;
        if (cmd.func == FUNC_CTRL) begin
            mdl_running = cmd.start_bit;
            mdl_reloading = cmd.auto_reload;
            if (cmd.manual_update) begin
                mdl_down_cnt = COUNT_W'(mdl_count_buf);
                mdl_pre_cnt = '0;
                mdl_div_cnt = '0;
            end
        end else if (mdl_running) begin
            sel_sat = (mdl_div_sel > 3'd4) ? 3'd4 : mdl_div_sel;
            div_term = DIV_CNT_W'((2 << sel_sat) - 1);
            if (mdl_pre_cnt >= mdl_prescale) begin
                mdl_pre_cnt = '0;
                if (mdl_div_cnt >= div_term) begin
                    mdl_div_cnt = '0;
                    divided_tick = 1'b1;
                end else begin
                    mdl_div_cnt = mdl_div_cnt + 1'b1;
                end
            end else begin
                mdl_pre_cnt = mdl_pre_cnt + 1'b1;
            end
            if (divided_tick) begin
                if (mdl_down_cnt != '0) begin
                    mdl_down_cnt = mdl_down_cnt - 1'b1;
                    if (mdl_down_cnt == '0) begin
                        obs.expired_irq = 1'b1;
                        if (mdl_reloading) mdl_down_cnt = COUNT_W'(mdl_count_buf);
                        else mdl_running = 1'b0;
                    end
                end else if (mdl_reloading) begin
                    mdl_down_cnt = COUNT_W'(mdl_count_buf);
                end else begin
                    mdl_running = 1'b0;
                end
            end
        end
        obs.count_observed = mdl_down_cnt;
        obs.is_running = mdl_running;
        return obs;
    endfunction

    // input driver
    always @(posedge i_clk) begin : drive_input
        t_timer_cmd nxt;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || o_s_tready) begin
            if (cmd_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = cmd_q.pop_front();
                s_valid <= 1'b1;
                s_tuser <= nxt.func;
                s_tdata <= {5'b0, nxt.auto_reload, nxt.manual_update, nxt.start_bit};
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // accepted input transfer: run the model
    always @(posedge i_clk) begin : predict_input
        t_timer_cmd cmd;
        if (i_rst_n && s_valid && o_s_tready) begin
            cmd.func = s_tuser;
            cmd.start_bit = s_tdata[0];
            cmd.manual_update = s_tdata[1];
            cmd.auto_reload = s_tdata[2];
            expected_obs_q.push_back(predict_timer_step(cmd));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cfg_valid && o_cfg_ready) begin
            case (cfg_index)
                CFG_PRESCALE:  mdl_prescale = cfg_data[PRESCALE_W-1:0];
                CFG_DIV_SEL:   mdl_div_sel = cfg_data[DIV_SEL_W-1:0];
                CFG_COUNT_BUF: mdl_count_buf = cfg_data[BUF_W-1:0];
                default: ;
            endcase
        end
    end

    // result monitor
    always @(posedge i_clk) begin : check_result
        t_timer_obs exp_obs;
        if (i_rst_n && o_m_tvalid && m_ready) begin
            if (expected_obs_q.size() == 0) begin
                $error("unexpected result transfer: tdata %h", o_m_tdata);
                err_count++;
            end else begin
                exp_obs = expected_obs_q.pop_front();
                if (o_m_tdata[15:0] !== exp_obs.count_observed) begin
                    $error("count_observed: expected %0d, got %0d",
                           exp_obs.count_observed, o_m_tdata[15:0]);
                    err_count++;
                end
                if (o_m_tdata[16] !== exp_obs.expired_irq) begin
                    $error("expired_irq: expected %0b, got %0b",
                           exp_obs.expired_irq, o_m_tdata[16]);
                    err_count++;
                end
                if (o_m_tdata[17] !== exp_obs.is_running) begin
                    $error("is_running: expected %0b, got %0b",
                           exp_obs.is_running, o_m_tdata[17]);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_tready) || (o_m_tvalid && m_ready)
                || (cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("prescaled_reload_down_timer test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_tick(input int n);
        t_timer_cmd cmd;
        cmd = '{func: FUNC_TICK, default: 1'b0};
        repeat (n) cmd_q.push_back(cmd);
    endtask

    task automatic push_ctrl(input logic start_bit, input logic manual_update,
                             input logic auto_reload);
        t_timer_cmd cmd;
        cmd.func = FUNC_CTRL;
        cmd.start_bit = start_bit;
        cmd.manual_update = manual_update;
        cmd.auto_reload = auto_reload;
        cmd_q.push_back(cmd);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    // upper data bits of the prescale and divider select writes are random; only the register width is kept
    task automatic set_timer_regs(input logic [PRESCALE_W-1:0] prescale,
                                  input logic [DIV_SEL_W-1:0] div_sel,
                                  input logic [BUF_W-1:0] count_buf);
        write_reg(CFG_PRESCALE, {8'($urandom()), prescale});
        write_reg(CFG_DIV_SEL, {13'($urandom()), div_sel});
        write_reg(CFG_COUNT_BUF, count_buf);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || s_valid || expected_obs_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // mostly start/update followed by a burst of ticks, with stray control writes and bare tick bursts
    task automatic add_random_items(input int n);
        int added;
        int burst;
        int pick;
        added = 0;
        while (added < n) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                burst = $urandom_range(1, 40);
                push_ctrl(1'b1, 1'b1, 1'($urandom_range(1)));
                push_tick(burst);
                added += burst + 1;
            end else if (pick < 80) begin
                push_ctrl(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
                added++;
            end else begin
                burst = $urandom_range(1, 12);
                push_tick(burst);
                added += burst;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_TICK;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PRESCALE;
        cfg_data = '0;
        err_count = 0;
        stall_cycles = 0;
        src_idle_pct = 13;
        snk_idle_pct = 50;
        mdl_prescale = '0;
        mdl_div_sel = '0;
        mdl_count_buf = '0;
        mdl_pre_cnt = '0;
        mdl_div_cnt = '0;
        mdl_down_cnt = '0;
        mdl_running = 1'b0;
        mdl_reloading = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fastest divide, count of three
        set_timer_regs(8'd0, 3'd0, 16'd3);
        push_tick(1);
        push_ctrl(1'b1, 1'b1, 1'b1);
        push_tick(7);
        push_ctrl(1'b0, 1'b0, 1'b0);
        push_tick(1);
        push_ctrl(1'b1, 1'b0, 1'b0);
        push_tick(6);
        push_tick(1);
        // running with a zero count, one shot then auto-reload
        push_ctrl(1'b1, 1'b0, 1'b0);
        push_tick(2);
        push_ctrl(1'b1, 1'b0, 1'b1);
        push_tick(2);
        wait_drained();

        set_timer_regs(8'd0, 3'd0, 16'($urandom_range(1, 8)));
        add_random_items(115);
        wait_drained();

        // divider select above four
        set_timer_regs(8'($urandom_range(3)), 3'd7, 16'($urandom_range(5)));
        add_random_items(115);
        wait_drained();

        src_idle_pct = 50;
        snk_idle_pct = 13;
        set_timer_regs(8'd255, 3'd4, 16'hffff);
        push_ctrl(1'b1, 1'b1, 1'b1);
        push_tick(200);
        add_random_items(100);
        wait_drained();

        // prescale lowered below the running phase, zero reload buffer
        set_timer_regs(8'd0, 3'd1, 16'd0);
        add_random_items(115);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_timer_regs(8'($urandom_range(2)), 3'($urandom_range(4)), 16'($urandom_range(1, 20)));
        add_random_items(115);
        wait_drained();

        set_timer_regs(8'd1, 3'd2, 16'd2);
        add_random_items(115);
        wait_drained();

        if (err_count == 0) begin
            $display("prescaled_reload_down_timer test passed");
        end else begin
            $display("prescaled_reload_down_timer test failed");
        end
        $finish;
    end

endmodule
